[hw/rtl/segmented_lru_region_bypass_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for segmented_lru_region_bypass
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SEGMENTED_LRU_REGION_BYPASS_ASSERT_SVH
`define SEGMENTED_LRU_REGION_BYPASS_ASSERT_SVH
`ifndef SYNTH
// Property that must hold at every clock edge out of reset.
`define SLRB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be true out of reset.
`define SLRB_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SLRB_ASSERT(lbl, prop, msg)
`define SLRB_NEVER(lbl, cond, msg)
`endif
`endif

[hw/rtl/slrb_pkg.sv]
// ----------------------------------------------------------------------------
// slrb_pkg
// Shared sizes, types and helper functions of the replacement policy block.
// ----------------------------------------------------------------------------
package slrb_pkg;

  localparam int SETS           = 2048;
  localparam int WAYS           = 16;
  localparam int REGION_ENTRIES = 4096;

  localparam int SET_W  = $clog2(SETS);
  localparam int REG_W  = $clog2(REGION_ENTRIES);
  localparam int WIDX_W = $clog2(WAYS);
  localparam int AGE_W  = $clog2(WAYS);
  localparam int VW     = 5;
  localparam int CNT_W  = 3;
  localparam int CLR_W  = (SET_W > REG_W) ? SET_W : REG_W;

  localparam logic [CNT_W-1:0] COUNT_MAX     = 3'd7;
  localparam logic [CNT_W-1:0] COUNT_RESET   = 3'd3;
  localparam logic [CNT_W-1:0] PROTECT_RESET = 3'd5;
  localparam logic [CNT_W-1:0] BYPASS_RESET  = 3'd1;

  localparam logic CFG_PROTECT = 1'b0;
  localparam logic CFG_BYPASS  = 1'b1;

  typedef struct packed {
    logic [WAYS-1:0][AGE_W-1:0] age;
    logic [WAYS-1:0]            prot;
    logic [WAYS-1:0]            valid;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  typedef struct packed {
    logic              is_victim;
    logic [SET_W-1:0]  set;
    logic [REG_W-1:0]  region;
    logic [WIDX_W-1:0] way;
    logic              hit;
  } q_entry_t;

  function automatic row_t reset_row();
    row_t r;
    r.valid = '0;
    r.prot  = '0;
    for (int w = 0; w < WAYS; w++) begin
      r.age[w] = AGE_W'(w);
    end
    return r;
  endfunction

  function automatic logic [WIDX_W-1:0] onehot_idx(logic [WAYS-1:0] oh);
    logic [WIDX_W-1:0] idx;
    idx = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (oh[w]) idx = idx | WIDX_W'(w);
    end
    return idx;
  endfunction

  // Lowest set bit, as a one-hot mask.
  function automatic logic [WAYS-1:0] first_one(logic [WAYS-1:0] m);
    logic [WAYS-1:0] oh;
    logic            seen;
    oh   = '0;
    seen = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      if (m[w] && !seen) oh[w] = 1'b1;
      seen = seen | m[w];
    end
    return oh;
  endfunction

  // Oldest way among the mask; on equal ages the lowest way wins.
  function automatic logic [WAYS-1:0] oldest(logic [WAYS-1:0] m,
                                              logic [WAYS-1:0][AGE_W-1:0] age);
    logic [WAYS-1:0] sel;
    sel = m;
    for (int w = 0; w < WAYS; w++) begin
      for (int v = 0; v < WAYS; v++) begin
        if (m[v] && ((age[v] > age[w]) || ((age[v] == age[w]) && (v < w))))
          sel[w] = 1'b0;
      end
    end
    return sel;
  endfunction

endpackage

[hw/rtl/slrb_ram.sv]
// ----------------------------------------------------------------------------
// slrb_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module slrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/slrb_front.sv]
// ----------------------------------------------------------------------------
// slrb_front
// Accepts request words, drops updates to no way, and queues the rest.
// ----------------------------------------------------------------------------
module slrb_front import slrb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        in_tuser,
  input  logic        clearing,
  output logic        q_valid,
  output q_entry_t    q_data,
  input  logic        q_pop
);

  q_entry_t    ent_r [2];
  logic        wptr_r, rptr_r;
  logic [1:0]  count_r;
  q_entry_t    ent;
  logic        keep, push;

  always_comb begin
    ent.is_victim = !in_tuser;
    ent.set       = in_tdata[SET_W-1:0];
    ent.region    = in_tdata[11 +: REG_W];
    ent.way       = in_tdata[23 +: WIDX_W];
    ent.hit       = in_tdata[28];
    // An update naming a way past the last one has no effect at all.
    keep      = !in_tuser || (in_tdata[27:23] < VW'(WAYS));
    in_tready = (count_r != 2'd2) && !clearing;
    push      = in_tvalid && in_tready && keep;
    q_valid   = (count_r != 2'd0);
    q_data    = ent_r[rptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) begin
        ent_r[wptr_r] <= ent;
        wptr_r        <= !wptr_r;
      end
      if (q_pop) rptr_r <= !rptr_r;
      count_r <= count_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

[hw/rtl/slrb_back.sv]
// ----------------------------------------------------------------------------
// slrb_back
// Executes queued requests against the set metadata and region counters.
// ----------------------------------------------------------------------------
`include "segmented_lru_region_bypass_assert.svh"
module slrb_back import slrb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  q_entry_t         q_data,
  output logic             q_pop,
  output logic             clearing,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CNT_W-1:0] cfg_wdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata
);

  typedef enum logic [1:0] {S_IDLE, S_CALC, S_WB} state_t;

  state_t           state_r;
  logic             clr_r;
  logic [CLR_W-1:0] clr_idx_r;
  logic [CNT_W-1:0] pth_r, bth_r;
  q_entry_t         job_r;
  row_t             row_r;
  logic [CNT_W-1:0] cnt_r;
  logic [VW-1:0]    victim_r;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [VW-1:0]    out_way_r;

  logic             row_we, cnt_we;
  logic [SET_W-1:0] row_waddr;
  logic [REG_W-1:0] cnt_waddr;
  logic [ROW_W-1:0] row_wdata, row_rdata;
  logic [CNT_W-1:0] cnt_wdata, cnt_rdata;

  row_t             rd_row, age_row_nxt, wb_row, wr_row;
  logic [VW-1:0]    victim_nxt;
  logic [CNT_W-1:0] wb_cnt;
  logic [AGE_W-1:0] old_age;
  logic [WAYS-1:0]  demote, zero_mask;
  logic             out_free, wb_go;

  always_comb begin
    q_pop    = (state_r == S_IDLE) && !clr_r && q_valid;
    clearing = clr_r;
    rd_row   = row_t'(row_rdata);

    if (cnt_rdata <= bth_r) begin
      victim_nxt = VW'(WAYS);
    end else if (~&rd_row.valid) begin
      victim_nxt = VW'(onehot_idx(first_one(~rd_row.valid)));
    end else if (~&rd_row.prot) begin
      victim_nxt = VW'(onehot_idx(oldest(~rd_row.prot, rd_row.age)));
    end else begin
      victim_nxt = VW'(onehot_idx(oldest({WAYS{1'b1}}, rd_row.age)));
    end

    age_row_nxt = rd_row;
    old_age     = rd_row.age[job_r.way];
    for (int w = 0; w < WAYS; w++) begin
      if (rd_row.age[w] < old_age) age_row_nxt.age[w] = rd_row.age[w] + AGE_W'(1);
    end
    age_row_nxt.age[job_r.way] = '0;

    wb_row = row_r;
    wb_cnt = cnt_r;
    demote = oldest(row_r.prot, row_r.age);
    if (job_r.hit) begin
      if (!row_r.prot[job_r.way] && (cnt_r >= pth_r)) begin
        wb_row.prot = (row_r.prot & ~demote) | (WAYS'(1) << job_r.way);
      end
      if (cnt_r < COUNT_MAX) wb_cnt = cnt_r + CNT_W'(1);
    end else begin
      wb_row.valid[job_r.way] = 1'b1;
      wb_row.prot[job_r.way]  = (cnt_r >= pth_r);
      if (cnt_r != '0) wb_cnt = cnt_r - CNT_W'(1);
    end

    out_free  = !out_valid_r || out_tready;
    wb_go     = (state_r == S_WB) && (!job_r.is_victim || out_free);
    out_valid_nxt = (out_valid_r && !out_tready) || (wb_go && job_r.is_victim);
    row_we    = clr_r || ((state_r == S_WB) && !job_r.is_victim);
    cnt_we    = row_we;
    row_waddr = clr_r ? clr_idx_r[SET_W-1:0] : job_r.set;
    cnt_waddr = clr_r ? clr_idx_r[REG_W-1:0] : job_r.region;
    wr_row    = clr_r ? reset_row() : wb_row;
    row_wdata = ROW_W'(wr_row);
    cnt_wdata = clr_r ? COUNT_RESET : wb_cnt;
    for (int w = 0; w < WAYS; w++) zero_mask[w] = (wr_row.age[w] == '0);
  end

  slrb_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_row_ram (
    .clk(clk), .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
    .re(q_pop), .raddr(q_data.set), .rdata(row_rdata)
  );

  slrb_ram #(.WIDTH(CNT_W), .DEPTH(REGION_ENTRIES)) u_cnt_ram (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .re(q_pop), .raddr(q_data.region), .rdata(cnt_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      clr_r       <= 1'b1;
      clr_idx_r   <= '0;
      pth_r       <= PROTECT_RESET;
      bth_r       <= BYPASS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == CFG_PROTECT)) pth_r <= cfg_wdata;
      if (cfg_we && (cfg_index == CFG_BYPASS))  bth_r <= cfg_wdata;
      if (clr_r) begin
        clr_idx_r <= clr_idx_r + CLR_W'(1);
        if (&clr_idx_r) clr_r <= 1'b0;
      end
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            job_r   <= q_data;
            state_r <= S_CALC;
          end
        end
        S_CALC: begin
          victim_r <= victim_nxt;
          row_r    <= age_row_nxt;
          cnt_r    <= cnt_rdata;
          state_r  <= S_WB;
        end
        S_WB: begin
          if (wb_go) begin
            if (job_r.is_victim) begin
              out_way_r <= victim_r;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(8-VW){1'b0}}, out_way_r};

  `SLRB_NEVER(a_no_pop_in_clear, clr_r && q_pop, "request started during clearing pass")
  `SLRB_ASSERT(a_way_range, out_valid_r |-> (out_way_r <= VW'(WAYS)), "victim out of range")
  `SLRB_ASSERT(a_age_perm, row_we |-> $onehot(zero_mask), "written row lacks one newest way")
  `SLRB_ASSERT(a_out_hold, (out_valid_r && !out_tready) |=> $stable(out_way_r), "result lost")

endmodule

[hw/rtl/segmented_lru_region_bypass.sv]
// ----------------------------------------------------------------------------
// segmented_lru_region_bypass
// Segmented LRU replacement policy with region-based fill bypass.
// ----------------------------------------------------------------------------
// After reset the block sweeps its metadata and region counter memories,
// one row of each per cycle, and accepts no request word until that pass
// ends; configuration writes are taken throughout. A request then passes
// through the execution stage in order: reading the set's metadata row and
// the region counter from their RAMs, comparing all ways in parallel and
// ageing the row, and writing back or handing the victim to the output
// register. Only one request is in execution at a time, so the next
// request always sees the finished state of the last; a two-entry queue in
// front lets the input keep flowing while a result waits to be taken.
// Victim requests (in_tuser low) give one output word; updates give none.
module segmented_lru_region_bypass import slrb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_tdata, from bit 0: set_index[10:0], region_index[22:11],
  // way[27:23], hit[28], zero fill [31:29].
  input  logic [31:0] in_tdata,
  // in_tuser: req_type (0 = victim request, 1 = update).
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata, from bit 0: victim_way[4:0], zero fill [7:5].
  output logic [7:0]  out_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [2:0]  cfg_wdata
);

  q_entry_t q_data;
  logic     q_valid, q_pop, clearing;

  // Front end: takes words, discards updates that name no way, queues work.
  slrb_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .clearing(clearing),
    .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
  );

  // Back end: owns the memories, thresholds and the output register.
  slrb_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop),
    .clearing(clearing),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

endmodule
